@@ rtl/shuffled_bag_index_generator_assert.svh @@
// ----------------------------------------------------------------------------
// shuffled_bag_index_generator_assert.svh
// Assertion macros used by the checker file of the bag index generator.
// ----------------------------------------------------------------------------
`ifndef SHUFFLED_BAG_INDEX_GENERATOR_ASSERT_SVH
`define SHUFFLED_BAG_INDEX_GENERATOR_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SBIG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define SBIG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sbig_pkg.sv @@
// ----------------------------------------------------------------------------
// sbig_pkg
// Types and constants of the shuffled bag index generator.
// ----------------------------------------------------------------------------
package sbig_pkg;

  localparam int unsigned KindW  = 2;
  localparam int unsigned SeedW  = 32;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned BagSize = 7;

  localparam logic [SeedW-1:0] SeedDefault = 32'h1234_ABCD;
  localparam logic [SeedW-1:0] DrawLimit   = 32'd4294967292;
  localparam logic [IdxW-1:0]  BagEmpty    = 3'd7;
  localparam logic [IdxW-1:0]  BagLast     = 3'd6;

  typedef enum logic [KindW-1:0] {
    KIND_DRAW   = 2'd0,
    KIND_REFILL = 2'd1,
    KIND_SEED   = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_GEN,
    ST_MOD,
    ST_READ,
    ST_WR_J,
    ST_WR_I,
    ST_FETCH,
    ST_OUT
  } sbig_state_e;

  // controller -> datapath
  typedef struct packed {
    logic seed_load;
    logic fill_start;
    logic fill_wr;
    logic gen_step;
    logic mod_step;
    logic swap_rd;
    logic wr_j;
    logic wr_i;
    logic fetch;
    logic out_load;
  } sbig_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic bag_empty;
    logic fill_last;
    logic reject;
    logic mod_last;
    logic idx_last;
    logic out_free;
  } sbig_sts_t;

endpackage

@@ rtl/sbig_if.sv @@
// ----------------------------------------------------------------------------
// sbig_if
// Valid/ready channels of the bag index generator: request in, index out.
// ----------------------------------------------------------------------------
interface sbig_in_if import sbig_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [SeedW-1:0] seed_value;

  modport source (output valid, output kind, output seed_value, input ready);
  modport sink   (input valid, input kind, input seed_value, output ready);
endinterface

interface sbig_out_if import sbig_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [IdxW-1:0] piece_index;

  modport source (output valid, output piece_index, input ready);
  modport sink   (input valid, input piece_index, output ready);
endinterface

@@ rtl/sbig_dp.sv @@
// ----------------------------------------------------------------------------
// sbig_dp
// Datapath: xorshift32 generator, bytewise remainder unit, bag memory,
// bag position and the output register.
// ----------------------------------------------------------------------------
module sbig_dp import sbig_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [SeedW-1:0] seed_i,
  input  sbig_cmd_t        cmd_i,
  output sbig_sts_t        sts_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [IdxW-1:0]  out_index_o
);

  logic [SeedW-1:0] gen_q, gen_d;
  logic [SeedW-1:0] x_next;
  logic [SeedW-1:0] v_q, v_d;
  logic [IdxW-1:0]  rem_q, rem_d;
  logic [1:0]       byte_cnt_q, byte_cnt_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [IdxW-1:0]  pos_q, pos_d;
  logic [IdxW-1:0]  divisor;
  logic             out_valid_q, out_valid_d;
  logic [IdxW-1:0]  out_idx_q;
  logic [IdxW-1:0]  rd_a_q, rd_b_q;
  logic [IdxW-1:0]  rd_addr_a;
  logic             mem_we;
  logic [IdxW-1:0]  mem_waddr, mem_wdata;
  logic [IdxW-1:0]  bag_mem [BagSize];

  // restoring remainder over one byte, MSB first; r < d on entry and exit
  function automatic logic [IdxW-1:0] rem_byte(input logic [IdxW-1:0] r,
                                               input logic [7:0] b,
                                               input logic [IdxW-1:0] d);
    logic [IdxW:0]   t;
    logic [IdxW-1:0] acc;
    acc = r;
    for (int k = 7; k >= 0; k--) begin
      t = {acc, b[k]};
      if (t >= {1'b0, d}) begin
        t = t - {1'b0, d};
      end
      acc = t[IdxW-1:0];
    end
    return acc;
  endfunction

  always_comb begin
    x_next = gen_q;
    x_next = x_next ^ (x_next << 13);
    x_next = x_next ^ (x_next >> 17);
    x_next = x_next ^ (x_next << 5);
  end

  assign divisor = idx_q + 3'd1;

  always_comb begin
    gen_d      = gen_q;
    v_d        = v_q;
    rem_d      = rem_q;
    byte_cnt_d = byte_cnt_q;
    idx_d      = idx_q;
    pos_d      = pos_q;
    if (cmd_i.seed_load) begin
      gen_d = (seed_i == '0) ? SeedDefault : seed_i;
    end
    if (cmd_i.gen_step) begin
      gen_d      = x_next;
      v_d        = x_next;
      rem_d      = '0;
      byte_cnt_d = '0;
    end
    if (cmd_i.mod_step) begin
      rem_d      = rem_byte(rem_q, v_q[SeedW-1 -: 8], divisor);
      v_d        = v_q << 8;
      byte_cnt_d = byte_cnt_q + 2'd1;
    end
    if (cmd_i.fill_start) begin
      idx_d = '0;
    end
    if (cmd_i.fill_wr && (idx_q != BagLast)) begin
      idx_d = idx_q + 3'd1;
    end
    if (cmd_i.wr_i) begin
      idx_d = idx_q - 3'd1;
      if (idx_q == 3'd1) begin
        pos_d = '0;
      end
    end
    if (cmd_i.fetch) begin
      pos_d = pos_q + 3'd1;
    end
  end

  // output register: a new index may load while the old one leaves
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q       <= SeedDefault;
      byte_cnt_q  <= '0;
      idx_q       <= '0;
      pos_q       <= BagEmpty;
      out_valid_q <= 1'b0;
    end else begin
      gen_q       <= gen_d;
      byte_cnt_q  <= byte_cnt_d;
      idx_q       <= idx_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    rem_q <= rem_d;
    if (cmd_i.out_load) begin
      out_idx_q <= rd_a_q;
    end
  end

  // bag memory: one write port, two registered read ports
  assign rd_addr_a = cmd_i.fetch ? pos_q : idx_q;
  assign mem_we    = cmd_i.fill_wr | cmd_i.wr_j | cmd_i.wr_i;
  assign mem_waddr = cmd_i.wr_j ? rem_q : idx_q;

  always_comb begin
    if (cmd_i.fill_wr) begin
      mem_wdata = idx_q;
    end else if (cmd_i.wr_j) begin
      mem_wdata = rd_a_q;
    end else begin
      mem_wdata = rd_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bag_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.swap_rd || cmd_i.fetch) begin
      rd_a_q <= bag_mem[rd_addr_a];
    end
    if (cmd_i.swap_rd) begin
      rd_b_q <= bag_mem[rem_q];
    end
  end

  assign sts_o.bag_empty = (pos_q == BagEmpty);
  assign sts_o.fill_last = (idx_q == BagLast);
  assign sts_o.reject    = (x_next >= DrawLimit);
  assign sts_o.mod_last  = (byte_cnt_q == 2'd3);
  assign sts_o.idx_last  = (idx_q == 3'd1);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_index_o = out_idx_q;

endmodule

@@ rtl/sbig_ctrl.sv @@
// ----------------------------------------------------------------------------
// sbig_ctrl
// Controller: decodes requests and sequences fill, shuffle and draw steps.
// ----------------------------------------------------------------------------
module sbig_ctrl import sbig_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [KindW-1:0] kind_i,
  input  sbig_sts_t        sts_i,
  output sbig_cmd_t        cmd_o
);

  sbig_state_e state_q, state_d;
  logic        draw_q, draw_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      draw_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      draw_q  <= draw_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    draw_d     = draw_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (kind_i)
            KIND_DRAW: begin
              draw_d = 1'b1;
              if (sts_i.bag_empty) begin
                cmd_o.fill_start = 1'b1;
                state_d          = ST_FILL;
              end else begin
                state_d = ST_FETCH;
              end
            end
            KIND_REFILL: begin
              draw_d           = 1'b0;
              cmd_o.fill_start = 1'b1;
              state_d          = ST_FILL;
            end
            KIND_SEED: begin
              draw_d           = 1'b0;
              cmd_o.seed_load  = 1'b1;
              cmd_o.fill_start = 1'b1;
              state_d          = ST_FILL;
            end
            default: begin
              // unused kind: transfer taken, nothing happens
            end
          endcase
        end
      end
      ST_FILL: begin
        cmd_o.fill_wr = 1'b1;
        if (sts_i.fill_last) begin
          state_d = ST_GEN;
        end
      end
      ST_GEN: begin
        cmd_o.gen_step = 1'b1;
        if (!sts_i.reject) begin
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.swap_rd = 1'b1;
        state_d       = ST_WR_J;
      end
      ST_WR_J: begin
        cmd_o.wr_j = 1'b1;
        state_d    = ST_WR_I;
      end
      ST_WR_I: begin
        cmd_o.wr_i = 1'b1;
        if (sts_i.idx_last) begin
          state_d = draw_q ? ST_FETCH : ST_IDLE;
        end else begin
          state_d = ST_GEN;
        end
      end
      ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = ST_OUT;
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          draw_d         = 1'b0;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/shuffled_bag_index_generator.sv @@
// ----------------------------------------------------------------------------
// shuffled_bag_index_generator
// Hands out indices 0..6 as successive random permutations (7-bag).
//
//   channel  dir  payload                 notes
//   in_i     in   kind, seed_value        draw / refill / seed + refill
//   out_o    out  piece_index             one transfer per draw
//
// Draw from a non-empty bag: ST_FETCH reads the bag memory, ST_OUT loads the
// output register once it is free. Refill: seven fill writes, then for each
// of six positions a generator step (redone per rejected word), four bytewise
// remainder steps, a swap read and two swap writes on the one write port.
// After reset the bag is empty, so the first draw refills first.
// in_i.ready is high only while the sequencer is idle; a held output stalls
// the next draw in its last step only.
// ----------------------------------------------------------------------------
module shuffled_bag_index_generator import sbig_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  sbig_in_if.sink    in_i,
  sbig_out_if.source out_o
);

  sbig_cmd_t cmd;
  sbig_sts_t sts;

  sbig_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .kind_i     (in_i.kind),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sbig_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seed_i      (in_i.seed_value),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_index_o (out_o.piece_index)
  );

endmodule

@@ rtl/sbig_checker.sv @@
// ----------------------------------------------------------------------------
// sbig_checker
// Port-level checks of the bag index generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "shuffled_bag_index_generator_assert.svh"

module sbig_checker import sbig_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic [KindW-1:0] in_kind_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [IdxW-1:0]  out_index_i
);

  `SBIG_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "output dropped while stalled")
  `SBIG_ASSERT_NEXT(a_out_stable, out_valid_i && !out_ready_i, $stable(out_index_i), "output changed while stalled")
  `SBIG_ASSERT_NOW(a_index_range, out_valid_i, out_index_i != BagEmpty, "index outside the bag")
  `SBIG_ASSERT_NEXT(a_refill_busy, in_valid_i && in_ready_i && (in_kind_i == KIND_REFILL || in_kind_i == KIND_SEED), !in_ready_i && ($rose(out_valid_i) == 1'b0), "refill did not start")

endmodule

bind shuffled_bag_index_generator sbig_checker u_sbig_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_kind_i   (in_i.kind),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_index_i (out_o.piece_index)
);

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the shuffled bag index generator. Draw, refill and
// seed requests go in with random bursts and gaps while the index channel
// stalls on its own pattern. A local xorshift/shuffle predictor computes every
// index, and each output transfer is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench import sbig_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned TailCycles = 200;
  localparam int unsigned NumRandom  = 850;
  localparam logic [KindW-1:0] KindIgnored = 2'd3;

  typedef struct {
    logic [KindW-1:0] kind;
    logic [SeedW-1:0] seed;
    bit               hold;  // wait for all indices before sending
  } bag_req_t;

  logic clk_i;
  logic rst_ni;

  sbig_in_if  in_if ();
  sbig_out_if out_if ();

  shuffled_bag_index_generator DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // predictor state
  logic [SeedW-1:0] gen_word;
  logic [IdxW-1:0]  bag_mem [BagSize];
  logic [IdxW-1:0]  bag_pos;

  bag_req_t        req_q[$];
  logic [IdxW-1:0] index_q[$];
  int unsigned     want_count;
  int unsigned     got_count;
  int unsigned     err_count;
  int unsigned     cycle_count;

  bag_req_t    cur_req;
  bit          in_busy;
  int unsigned burst_left;
  int unsigned gap_left;

  int unsigned stall_mode;
  int unsigned stall_window;
  logic [12:0] stall_pat;

  function automatic logic [SeedW-1:0] xs_unbiased();
    logic [SeedW-1:0] x;
    do begin
      x = gen_word;
      x ^= x << 13;
      x ^= x >> 17;
      x ^= x << 5;
      gen_word = x;
    end while (x >= DrawLimit);
    return x;
  endfunction

  function automatic void bag_shuffle();
    logic [IdxW-1:0] t;
    int unsigned     j;
    for (int unsigned i = 0; i < BagSize; i++) bag_mem[i] = IdxW'(i);
    for (int unsigned i = BagSize - 1; i > 0; i--) begin
      j = xs_unbiased() % (i + 1);
      t = bag_mem[i];
      bag_mem[i] = bag_mem[j];
      bag_mem[j] = t;
    end
    bag_pos = '0;
  endfunction

  function automatic void bag_apply(logic [KindW-1:0] kind, logic [SeedW-1:0] seed);
    case (kind)
      KIND_DRAW: begin
        if (bag_pos >= BagSize) bag_shuffle();
        index_q.push_back(bag_mem[bag_pos]);
        bag_pos = bag_pos + 1'b1;
        want_count++;
      end
      KIND_REFILL: bag_shuffle();
      KIND_SEED: begin
        gen_word = (seed == '0) ? SeedDefault : seed;
        bag_shuffle();
      end
      default: ;  // unknown kind: no effect
    endcase
  endfunction

  task automatic add_req(logic [KindW-1:0] kind, logic [SeedW-1:0] seed, bit hold = 1'b0);
    bag_req_t r;
    r.kind = kind;
    r.seed = seed;
    r.hold = hold;
    req_q.push_back(r);
  endtask

  task automatic report(string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic pick_burst();
    if ($urandom_range(0, 9) < 2) begin
      burst_left = $urandom_range(30, 80);
      gap_left   = 0;
    end else begin
      burst_left = $urandom_range(1, 12);
      gap_left   = $urandom_range(1, 10);
    end
  endtask

  // clock, reset, known inputs from time zero
  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.kind = '0;
    in_if.seed_value = '0;
    out_if.ready = 1'b0;
    fork
      forever #6 clk_i = ~clk_i;
      begin
        repeat (9) @(posedge clk_i);
        rst_ni <= 1'b1;
      end
    join_none
  end

  initial begin
    cycle_count = 0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_busy = 1'b0;
      pick_burst();
    end else begin
      if (in_if.valid && in_if.ready) begin
        bag_apply(cur_req.kind, cur_req.seed);
        in_busy = 1'b0;
      end
      if (!in_busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (req_q.size() > 0 && !(req_q[0].hold && got_count < want_count)) begin
          cur_req = req_q.pop_front();
          in_busy = 1'b1;
          in_if.kind <= cur_req.kind;
          in_if.seed_value <= cur_req.seed;
          burst_left--;
          if (burst_left == 0) pick_burst();
        end
      end
      in_if.valid <= in_busy;
    end
  end

  // index monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    logic [IdxW-1:0] want_idx;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      got_count <= 0;
      stall_mode = 0;
      stall_window = 40;
      stall_pat = 13'b1011001110001;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (index_q.size() == 0) begin
          report($sformatf("index %0d with no draw pending", out_if.piece_index));
        end else begin
          want_idx = index_q.pop_front();
          if (out_if.piece_index !== want_idx)
            report($sformatf("piece_index %0d, predicted %0d", out_if.piece_index, want_idx));
          got_count <= got_count + 1;
        end
      end
      stall_window--;
      if (stall_window == 0) begin
        stall_window = $urandom_range(20, 120);
        stall_mode = $urandom_range(0, 3);
        stall_pat = 13'($urandom);
        if (stall_pat == '0) stall_pat = 13'h1;
      end
      stall_pat = {stall_pat[11:0], stall_pat[12]};
      case (stall_mode)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= stall_pat[0];
        2:       out_if.ready <= ($urandom_range(0, 3) != 0);
        default: out_if.ready <= stall_pat[12] | stall_pat[5];
      endcase
    end
  end

  // stimulus and end of run
  initial begin
    int unsigned n;
    int unsigned r;
    logic [SeedW-1:0] s;
    err_count = 0;
    want_count = 0;
    gen_word = SeedDefault;
    bag_pos = BagEmpty;
    for (int i = 0; i < BagSize; i++) bag_mem[i] = '0;

    // first draw refills the empty bag; then empty it and draw past the end
    repeat (7) add_req(KIND_DRAW, $urandom);
    add_req(KIND_DRAW, $urandom);
    add_req(KindIgnored, $urandom);
    add_req(KIND_REFILL, $urandom);
    add_req(KIND_DRAW, '0);
    add_req(KIND_DRAW, '1, 1'b1);
    add_req(KIND_SEED, '0);            // zero seed falls back to default
    add_req(KIND_DRAW, $urandom);
    add_req(KIND_SEED, '1);
    add_req(KIND_DRAW, $urandom);
    add_req(KIND_SEED, 32'h1);
    add_req(KIND_DRAW, $urandom);
    add_req(KIND_SEED, 32'h8000_0000);
    add_req(KIND_DRAW, $urandom);
    add_req(KindIgnored, '1);
    add_req(KIND_DRAW, $urandom);

    n = 0;
    while (n < NumRandom) begin
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0:       s = '0;
        1:       s = SeedW'(1) << $urandom_range(0, SeedW - 1);
        2:       s = '1;
        default: s = $urandom;
      endcase
      if (r < 72) begin
        add_req(KIND_DRAW, s, ($urandom_range(0, 120) == 0));
      end else if (r < 82) begin
        add_req(KIND_REFILL, s);
      end else if (r < 94) begin
        add_req(KIND_SEED, s);
      end else begin
        add_req(KindIgnored, s);
      end
      n++;
    end

    @(posedge rst_ni);
    while (req_q.size() > 0 || in_busy) @(posedge clk_i);
    while (got_count < want_count) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (index_q.size() != 0)
      report($sformatf("%0d predicted indices never arrived", index_q.size()));
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/sbig_pkg.sv
rtl/sbig_if.sv
rtl/sbig_dp.sv
rtl/sbig_ctrl.sv
rtl/shuffled_bag_index_generator.sv
rtl/sbig_checker.sv
tb/sv/testbench.sv
